### rtl/core/cbcx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbcx_pkg
// Shared types, register indexes and a byte helper for the byte-serial CBC XOR
// cipher with PKCS#7 padding.
// ----------------------------------------------------------------------------
package cbcx_pkg;

    // default block size in bytes (1 to 16)
    localparam int BLOCK_BYTES_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_W      = 128;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH   = 3'd4;

    // end-of-message status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PAD  = 2'd1,
        ST_RAGGED   = 2'd2,
        ST_NO_BLOCK = 2'd3
    } t_status;

    // input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_message;
        t_status    status;
    } t_out_beat;

    // live configuration seen by the engine
    typedef struct packed {
        logic             dir;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] iv;
    } t_cfg;

    // byte i of a 16-byte word, byte 0 in the low bits
    function automatic logic [7:0] pick_byte(input logic [KEY_W-1:0] w, input logic [3:0] i);
        logic [6:0] base;
        base = {i, 3'b000};
        return w[base +: 8];
    endfunction

endpackage
`default_nettype wire

### rtl/core/cbcx_chan_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbcx_chan_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface cbcx_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/core/cbcx_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbcx_engine
// Holds one input beat and walks it through IV, data, pad and tail steps,
// at most one result per step, with the chain and held-plaintext block stores.
// ----------------------------------------------------------------------------
module cbcx_engine
    import cbcx_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_dir_wr,
    input  wire logic      i_item_valid,
    input  wire t_in_beat  i_item,
    output logic           o_item_ready,
    input  wire logic      i_slot_free,
    output logic           o_emit,
    output t_out_beat      o_res
);

    localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
    localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
    localparam logic [IDX_W-1:0] POS_LAST  = IDX_W'(BLOCK_BYTES - 1);
    localparam logic [CNT_W-1:0] BLK_CNT   = CNT_W'(BLOCK_BYTES);
    localparam logic [7:0]       BLK_BYTE  = 8'(BLOCK_BYTES);
    localparam logic [7:0]       LAST_BYTE = 8'(BLOCK_BYTES - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_IV   = 5'b00010,
        S_DATA = 5'b00100,
        S_PAD  = 5'b01000,
        S_TAIL = 5'b10000
    } t_state;

    t_state           r_state;
    logic [7:0]       r_byte;
    logic             r_fin;
    logic [IDX_W-1:0] r_pos;
    logic             r_started;
    logic             r_reading_iv;
    logic             r_held_valid;
    logic             r_ragged;
    logic [CNT_W-1:0] r_padv;
    logic [7:0]       r_chain [BLOCK_BYTES];
    logic [7:0]       r_held  [BLOCK_BYTES];

    logic [IDX_W-1:0] n_pos;
    logic             n_started;
    logic             n_reading_iv;
    logic             n_held_valid;
    logic             n_ragged;
    logic [CNT_W-1:0] n_padv;
    t_state           n_state;

    logic             w_emit;
    logic             w_done;
    logic             w_busy;
    logic             w_go;
    logic             w_accept;
    logic             w_chain_we;
    logic [7:0]       w_chain_wd;
    logic             w_held_we;
    t_state           w_step_state;
    t_state           w_start_state;
    logic             w_pos_last;
    logic [IDX_W-1:0] w_pos_inc;
    logic [7:0]       w_key_b;
    logic [7:0]       w_iv_b;
    logic [7:0]       w_chain_b;
    logic [7:0]       w_held_b;
    logic [7:0]       w_xor_in;
    logic [7:0]       w_xor;
    logic [7:0]       w_padb;
    logic             w_pad_bad;
    logic             w_keep_none;
    logic             w_tail_end;

    // per-position operands
    assign w_pos_last = (r_pos == POS_LAST);
    assign w_pos_inc  = w_pos_last ? '0 : r_pos + IDX_W'(1);
    assign w_key_b    = pick_byte(i_cfg.key, 4'(r_pos));
    assign w_iv_b     = pick_byte(i_cfg.iv, 4'(r_pos));
    assign w_chain_b  = r_chain[r_pos];
    assign w_held_b   = r_held[r_pos];
    assign w_xor_in   = (r_state == S_PAD) ? 8'(r_padv) : r_byte;
    assign w_xor      = w_xor_in ^ w_key_b ^ w_chain_b;

    // pad check on the last held block
    assign w_padb      = r_held[POS_LAST];
    assign w_pad_bad   = (w_padb == 8'd0) || (w_padb > BLK_BYTE);
    assign w_keep_none = (w_padb == BLK_BYTE);
    assign w_tail_end  = ((8'(r_pos) + w_padb) == LAST_BYTE);

    // step decode
    always_comb begin
        w_emit       = 1'b0;
        w_done       = 1'b0;
        o_res        = '0;
        o_res.status = ST_OK;
        n_pos        = r_pos;
        n_started    = r_started;
        n_reading_iv = r_reading_iv;
        n_held_valid = r_held_valid;
        n_ragged     = r_ragged;
        n_padv       = r_padv;
        w_chain_we   = 1'b0;
        w_chain_wd   = w_xor;
        w_held_we    = 1'b0;
        w_step_state = r_state;
        case (r_state)
            S_IV: begin
                w_emit          = 1'b1;
                o_res.out_byte  = w_iv_b;
                o_res.has_byte  = 1'b1;
                w_chain_we      = 1'b1;
                w_chain_wd      = w_iv_b;
                n_pos           = w_pos_inc;
                if (w_pos_last) begin
                    n_started    = 1'b1;
                    w_step_state = S_DATA;
                end
            end
            S_DATA: begin
                if (!i_cfg.dir) begin
                    // encrypt one byte
                    w_emit         = 1'b1;
                    o_res.out_byte = w_xor;
                    o_res.has_byte = 1'b1;
                    w_chain_we     = 1'b1;
                    n_pos          = w_pos_inc;
                    if (r_fin) begin
                        n_padv       = BLK_CNT - CNT_W'(w_pos_inc);
                        w_step_state = S_PAD;
                    end else begin
                        w_done = 1'b1;
                    end
                end else if (r_reading_iv) begin
                    // decrypt: absorb the IV
                    n_started  = 1'b1;
                    w_chain_we = 1'b1;
                    w_chain_wd = r_byte;
                    n_pos      = w_pos_inc;
                    if (w_pos_last) begin
                        n_reading_iv = 1'b0;
                    end
                    w_done = 1'b1;
                    if (r_fin) begin
                        w_emit               = 1'b1;
                        o_res.end_of_message = 1'b1;
                        o_res.status         = ST_NO_BLOCK;
                        n_pos                = '0;
                        n_started            = 1'b0;
                        n_reading_iv         = 1'b1;
                        n_held_valid         = 1'b0;
                    end
                end else begin
                    // decrypt: release previous block byte, hold the new one
                    w_emit         = r_held_valid;
                    o_res.out_byte = w_held_b;
                    o_res.has_byte = 1'b1;
                    w_chain_we     = 1'b1;
                    w_chain_wd     = r_byte;
                    w_held_we      = 1'b1;
                    n_started      = 1'b1;
                    n_pos          = w_pos_inc;
                    if (w_pos_last) begin
                        n_held_valid = 1'b1;
                    end
                    if (r_fin) begin
                        n_ragged     = !w_pos_last;
                        w_step_state = S_TAIL;
                    end else begin
                        w_done = 1'b1;
                    end
                end
            end
            S_PAD: begin
                w_emit               = 1'b1;
                o_res.out_byte       = w_xor;
                o_res.has_byte       = 1'b1;
                o_res.end_of_message = w_pos_last;
                w_chain_we           = 1'b1;
                n_pos                = w_pos_inc;
                if (w_pos_last) begin
                    w_done       = 1'b1;
                    n_pos        = '0;
                    n_started    = 1'b0;
                    n_reading_iv = 1'b1;
                    n_held_valid = 1'b0;
                end
            end
            S_TAIL: begin
                w_emit = 1'b1;
                if (r_ragged) begin
                    o_res.end_of_message = 1'b1;
                    o_res.status         = ST_RAGGED;
                    w_done               = 1'b1;
                end else if (w_pad_bad) begin
                    o_res.end_of_message = 1'b1;
                    o_res.status         = ST_BAD_PAD;
                    w_done               = 1'b1;
                end else if (w_keep_none) begin
                    o_res.end_of_message = 1'b1;
                    w_done               = 1'b1;
                end else begin
                    o_res.out_byte       = w_held_b;
                    o_res.has_byte       = 1'b1;
                    o_res.end_of_message = w_tail_end;
                    w_done               = w_tail_end;
                    n_pos                = w_pos_inc;
                end
                if (w_done) begin
                    n_pos        = '0;
                    n_started    = 1'b0;
                    n_reading_iv = 1'b1;
                    n_held_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // handshake with the input and output sides
    assign w_busy       = (r_state != S_IDLE);
    assign w_go         = w_busy && (!w_emit || i_slot_free);
    assign o_emit       = w_go && w_emit;
    assign o_item_ready = !w_busy || (w_go && w_done);
    assign w_accept     = i_item_valid && o_item_ready;

    // first step of a new item follows the framing left by this one
    assign w_start_state = (!i_cfg.dir && !(w_go ? n_started : r_started)) ? S_IV : S_DATA;

    always_comb begin
        n_state = r_state;
        if (o_item_ready) begin
            n_state = w_accept ? w_start_state : S_IDLE;
        end else if (w_go) begin
            n_state = w_step_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_started    <= 1'b0;
            r_reading_iv <= 1'b1;
            r_held_valid <= 1'b0;
            r_ragged     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_dir_wr) begin
                r_pos        <= '0;
                r_started    <= 1'b0;
                r_reading_iv <= 1'b1;
                r_held_valid <= 1'b0;
            end else if (w_go) begin
                r_pos        <= n_pos;
                r_started    <= n_started;
                r_reading_iv <= n_reading_iv;
                r_held_valid <= n_held_valid;
                r_ragged     <= n_ragged;
            end
        end
    end

    // input beat and pad value
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_item.data_byte;
            r_fin  <= i_item.final_byte;
        end
        if (w_go) begin
            r_padv <= n_padv;
        end
    end

    // chain and held block stores
    always_ff @(posedge i_clk) begin
        if (w_go && w_chain_we) begin
            r_chain[r_pos] <= w_chain_wd;
        end
        if (w_go && w_held_we) begin
            r_held[r_pos] <= w_xor;
        end
    end

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("block position beyond the block");

    a_iv_vs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reading_iv |-> !r_held_valid)
        else $error("held block while still reading the IV");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && w_done && !w_accept) |=> (r_state == S_IDLE))
        else $error("engine stayed busy after finishing an item");
`endif

endmodule
`default_nettype wire

### rtl/core/cbc_xor_block_cipher_pkcs7_top.sv
`default_nettype none
// Results are registered in the output register. Throughput: one input beat per cycle
// while each beat yields at most one result and the output is not stalled; the engine
// emits one result per cycle while the output has room, so a message's first encrypt
// beat holds the input during the IV, a final beat during the pad or tail bytes.
// Reset (synchronous, active low) zeroes the configuration registers, clears framing and the output valid.
// ----------------------------------------------------------------------------
// cbc_xor_block_cipher_pkcs7_top
// Byte-serial CBC chaining with an XOR block function and PKCS#7 framing:
// configuration registers, the step engine and the output register.
// ----------------------------------------------------------------------------
module cbc_xor_block_cipher_pkcs7_top
    import cbcx_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    cbcx_chan_if.sink                  i_in,
    cbcx_chan_if.source                o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic             r_dir;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_iv;
    logic             r_ov;
    t_out_beat        r_out;

    t_cfg      w_cfg;
    t_in_beat  w_item;
    t_out_beat w_res;
    logic      w_dir_wr;
    logic      w_item_ready;
    logic      w_slot_free;
    logic      w_emit;

    // configuration registers
    assign w_dir_wr = i_cfg_we && (i_cfg_index == REG_DIRECTION);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= 1'b0;
            r_key <= '0;
            r_iv  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DIRECTION: r_dir                     <= i_cfg_data[0];
                REG_KEY_LOW:   r_key[CFG_DATA_W-1:0]     <= i_cfg_data;
                REG_KEY_HIGH:  r_key[KEY_W-1:CFG_DATA_W] <= i_cfg_data;
                REG_IV_LOW:    r_iv[CFG_DATA_W-1:0]      <= i_cfg_data;
                REG_IV_HIGH:   r_iv[KEY_W-1:CFG_DATA_W]  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.dir = r_dir;
    assign w_cfg.key = r_key;
    assign w_cfg.iv  = r_iv;

    // input beat into the engine
    assign w_item     = i_in.payload;
    assign i_in.ready = w_item_ready;

    cbcx_engine #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_dir_wr     (w_dir_wr),
        .i_item_valid (i_in.valid),
        .i_item       (w_item),
        .o_item_ready (w_item_ready),
        .i_slot_free  (w_slot_free),
        .o_emit       (w_emit),
        .o_res        (w_res)
    );

    // output register
    assign w_slot_free = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid   = r_ov;
    assign o_out.payload = r_out;

`ifndef NO_ASSERTIONS
    a_emit_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_slot_free)
        else $error("result produced with the output register full");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(w_emit))
        else $error("output valid without a result from the engine");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_out.ready) |=> (r_ov && $stable(r_out)))
        else $error("output beat changed while waiting");
`endif

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte-serial CBC XOR cipher with PKCS#7 framing.
// Encrypt and decrypt streams are driven with random gaps and output stalls.
// A local predictor expects every output beat, and the beats are checked in
// order.
// ----------------------------------------------------------------------------
module tb;
    import cbcx_pkg::*;

    localparam int NB         = BLOCK_BYTES_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE     = 4;
    localparam int LONG_HOLD  = 300;
    localparam int RAND_BEATS = 380;
    localparam int PAUSE_ODDS = 64;

    // indexes past the register list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // shapes of decrypt streams
    typedef enum int {
        DK_GOOD,
        DK_FULL_PAD,
        DK_PAD_ZERO,
        DK_PAD_HIGH,
        DK_RAGGED,
        DK_SHORT_IV,
        DK_NOISE
    } t_frame_kind;
    localparam int N_KINDS = 7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cbcx_chan_if #(.t_payload(t_in_beat))  in_ch ();
    cbcx_chan_if #(.t_payload(t_out_beat)) out_ch ();

    cbc_xor_block_cipher_pkcs7_top #(
        .BLOCK_BYTES (NB)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state: configuration copy and cipher state
    logic             dir_decrypt;
    logic [KEY_W-1:0] key_word;
    logic [KEY_W-1:0] iv_word;
    logic [7:0]       chain_bytes [NB];
    logic [7:0]       held_bytes  [NB];
    int               blk_pos;
    logic             msg_open;
    logic             iv_phase;
    logic             held_full;

    t_out_beat  out_beats_q [$];   // predicted output beats, oldest first
    logic [7:0] frame_q [$];       // byte stream of the next message

    int tx_gap_max   = 15;
    int rx_stall_max = 15;
    int rx_hold_req  = 0;
    int beats_sent   = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;

    function automatic void reset_framing();
        blk_pos   = 0;
        msg_open  = 1'b0;
        iv_phase  = 1'b1;
        held_full = 1'b0;
    endfunction

    function automatic void push_beat(input logic [7:0] b, input logic has, input logic eom,
                                      input t_status st);
        t_out_beat ob;
        ob.out_byte       = b;
        ob.has_byte       = has;
        ob.end_of_message = eom;
        ob.status         = st;
        out_beats_q.push_back(ob);
    endfunction

    function automatic void step_pos();
        blk_pos = (blk_pos + 1 >= NB) ? 0 : blk_pos + 1;
    endfunction

    // encrypt one byte at the current position and chain it
    function automatic logic [7:0] seal_byte(input logic [7:0] p);
        logic [7:0] c;
        c = p ^ key_word[8*blk_pos +: 8] ^ chain_bytes[blk_pos];
        chain_bytes[blk_pos] = c;
        step_pos();
        return c;
    endfunction

    function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DIRECTION: begin
                dir_decrypt = data[0];
                reset_framing();
            end
            REG_KEY_LOW:  key_word[63:0]   = data;
            REG_KEY_HIGH: key_word[127:64] = data;
            REG_IV_LOW:   iv_word[63:0]    = data;
            REG_IV_HIGH:  iv_word[127:64]  = data;
            default: ;
        endcase
    endfunction

    // expected output beats for one accepted input beat
    function automatic void cbc_step(input logic [7:0] b, input logic fin);
        int         pad;
        int         keep;
        int         pos;
        logic [7:0] p;
        if (!dir_decrypt) begin
            // a new message opens with the IV in clear
            if (!msg_open) begin
                for (int k = 0; k < NB; k++) begin
                    chain_bytes[k] = iv_word[8*k +: 8];
                    push_beat(chain_bytes[k], 1'b1, 1'b0, ST_OK);
                end
                msg_open = 1'b1;
                blk_pos  = 0;
            end
            push_beat(seal_byte(b), 1'b1, 1'b0, ST_OK);
            // pkcs7 pad up to the block boundary, a whole block if aligned
            if (fin) begin
                pad = NB - blk_pos;
                for (int k = 0; k < pad; k++)
                    push_beat(seal_byte(8'(pad)), 1'b1, k + 1 == pad, ST_OK);
                reset_framing();
            end
            return;
        end

        msg_open = 1'b1;
        pos      = blk_pos;
        // leading block loads the chain
        if (iv_phase) begin
            chain_bytes[pos] = b;
            if (pos + 1 >= NB)
                iv_phase = 1'b0;
            step_pos();
            if (fin) begin
                push_beat(8'h00, 1'b0, 1'b1, ST_NO_BLOCK);
                reset_framing();
            end
            return;
        end

        // release the held byte of the previous block, hold the new one
        p = b ^ key_word[8*pos +: 8] ^ chain_bytes[pos];
        chain_bytes[pos] = b;
        if (held_full)
            push_beat(held_bytes[pos], 1'b1, 1'b0, ST_OK);
        held_bytes[pos] = p;
        if (pos + 1 >= NB)
            held_full = 1'b1;
        step_pos();
        if (fin) begin
            if (pos + 1 < NB) begin
                push_beat(8'h00, 1'b0, 1'b1, ST_RAGGED);
            end else begin
                pad = held_bytes[NB-1];
                if (pad >= 1 && pad <= NB) begin
                    keep = NB - pad;
                    for (int k = 0; k < keep; k++)
                        push_beat(held_bytes[k], 1'b1, k + 1 == keep, ST_OK);
                    if (keep == 0)
                        push_beat(8'h00, 1'b0, 1'b1, ST_OK);
                end else begin
                    push_beat(8'h00, 1'b0, 1'b1, ST_BAD_PAD);
                end
            end
            reset_framing();
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_word();
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // random plaintext of the given length
    function automatic void build_plain(input int len);
        frame_q.delete();
        repeat (len) frame_q.push_back(8'($urandom));
    endfunction

    // iv block plus ciphertext under the current key, shaped by kind
    function automatic void build_cipher(input t_frame_kind kind);
        logic [7:0] link [NB];
        logic [7:0] plain [$];
        int         n;
        int         pad;
        int         cut;
        frame_q.delete();
        if (kind == DK_NOISE) begin
            n = $urandom_range(40, 1);
            repeat (n) frame_q.push_back(8'($urandom));
            return;
        end
        for (int k = 0; k < NB; k++) begin
            link[k] = 8'($urandom);
            frame_q.push_back(link[k]);
        end
        // message ends inside the iv, or on its last byte
        if (kind == DK_SHORT_IV) begin
            cut = ($urandom_range(1, 0) == 1) ? 0 : $urandom_range(NB - 1, 1);
            repeat (cut) void'(frame_q.pop_back());
            return;
        end
        n = (kind == DK_FULL_PAD) ? NB * $urandom_range(2, 0) : $urandom_range(24, 0);
        repeat (n) plain.push_back(8'($urandom));
        pad = NB - (n % NB);
        repeat (pad) plain.push_back(8'(pad));
        if (kind == DK_PAD_ZERO)
            plain[plain.size()-1] = 8'h00;
        if (kind == DK_PAD_HIGH)
            plain[plain.size()-1] = 8'($urandom_range(255, NB + 1));
        for (int k = 0; k < plain.size(); k++) begin
            link[k % NB] = plain[k] ^ key_word[8*(k % NB) +: 8] ^ link[k % NB];
            frame_q.push_back(link[k % NB]);
        end
        if (kind == DK_RAGGED) begin
            cut = $urandom_range(NB - 1, 1);
            repeat (cut) void'(frame_q.pop_back());
        end
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // register write, called and returning at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        mirror_reg(idx, data);
        @(negedge clk);
    endtask

    // offer one input beat after a random gap, predict on acceptance
    task automatic send_beat(input logic [7:0] b, input logic fin);
        int       gap;
        t_in_beat ib;
        gap = $urandom_range(tx_gap_max, 0);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        ib.data_byte  = b;
        ib.final_byte = fin;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= ib;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        cbc_step(b, fin);
        beats_sent++;
        @(negedge clk);
    endtask

    // stop offering, let every predicted beat arrive, then let the engine settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (out_beats_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // send frame_q as one message, sometimes pausing until drained
    task automatic send_frame(input int pause_odds);
        for (int k = 0; k < frame_q.size(); k++) begin
            send_beat(frame_q[k], k == frame_q.size() - 1);
            if (pause_odds > 0 && k < frame_q.size() - 1
                    && $urandom_range(pause_odds - 1, 0) == 0)
                wait_idle();
        end
    endtask

    // single-byte messages under reset settings and under extreme key and iv
    task automatic test_encrypt_edges();
        build_plain(1);
        frame_q[0] = 8'h00;
        send_frame(0);
        wait_idle();
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, '0);
        write_reg(REG_IV_LOW, '0);
        write_reg(REG_IV_HIGH, '1);
        build_plain(1);
        frame_q[0] = 8'hFF;
        send_frame(0);
        wait_idle();
    endtask

    // key and iv writes in the middle of an encrypt message
    task automatic test_live_key_write();
        repeat (3) send_beat(8'($urandom), 1'b0);
        wait_idle();
        write_reg(REG_KEY_HIGH, pick_word());
        write_reg(REG_IV_LOW, {$urandom, $urandom});
        send_beat(8'($urandom), 1'b1);
        wait_idle();
    endtask

    // direction writes abort messages in either direction
    task automatic test_direction_abort();
        repeat (2) send_beat(8'($urandom), 1'b0);
        wait_idle();
        write_reg(REG_DIRECTION, 64'd1);
        send_beat(8'($urandom), 1'b1);
        repeat (5) send_beat(8'($urandom), 1'b0);
        wait_idle();
        write_reg(REG_DIRECTION, 64'd0);
        send_beat(8'($urandom), 1'b1);
        wait_idle();
    endtask

    // writes past the register list change nothing
    task automatic test_spare_index();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, {$urandom, $urandom});
        send_beat(8'($urandom), 1'b1);
        wait_idle();
    endtask

    // receiver holds off while the sender streams, filling the block
    task automatic test_backpressure();
        tx_gap_max  = 0;
        rx_hold_req = LONG_HOLD;
        build_plain(30);
        send_frame(0);
        wait_idle();
        tx_gap_max = 15;
    endtask

    // random settings, alternating direction, well-formed and broken streams
    task automatic test_random_traffic();
        int   start;
        int   phase;
        int   dec_count;
        logic first_enc;
        start     = beats_sent;
        phase     = 0;
        dec_count = 0;
        first_enc = 1'b1;
        while (beats_sent < start + RAND_BEATS) begin
            wait_idle();
            write_reg(REG_DIRECTION, 64'(phase % 2));
            if ($urandom_range(1, 0) == 1) write_reg(REG_KEY_LOW, pick_word());
            if ($urandom_range(1, 0) == 1) write_reg(REG_KEY_HIGH, pick_word());
            if ($urandom_range(1, 0) == 1) write_reg(REG_IV_LOW, pick_word());
            if ($urandom_range(1, 0) == 1) write_reg(REG_IV_HIGH, pick_word());
            repeat ($urandom_range(3, 1) + (phase % 2)) begin
                tx_gap_max   = ($urandom_range(2, 0) == 0) ? 0 : 15;
                rx_stall_max = ($urandom_range(2, 0) == 0) ? 0 : 15;
                if (!dir_decrypt) begin
                    build_plain(first_enc ? NB : $urandom_range(40, 1));
                    first_enc = 1'b0;
                end else begin
                    build_cipher(t_frame_kind'(dec_count % N_KINDS));
                    dec_count++;
                end
                send_frame(PAUSE_ODDS);
            end
            phase++;
        end
        tx_gap_max   = 15;
        rx_stall_max = 15;
    endtask

    // output side: random stalls per beat, or one long hold on request
    initial begin : rx_side
        int stall;
        out_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            stall = $urandom_range(rx_stall_max, 0);
            if (rx_hold_req > 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
            @(negedge clk);
        end
    end

    // compare each accepted output beat with the oldest prediction
    always @(posedge clk) begin : out_check
        t_out_beat want;
        t_out_beat got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = out_ch.payload;
            if (out_beats_q.size() == 0) begin
                flag_error($sformatf("unexpected beat: byte %02h has %0b eom %0b status %0d",
                                     got.out_byte, got.has_byte, got.end_of_message,
                                     got.status));
            end else begin
                want = out_beats_q.pop_front();
                if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte
                        || got.end_of_message !== want.end_of_message
                        || got.status !== want.status)
                    flag_error($sformatf({"beat mismatch: expected byte %02h has %0b eom %0b ",
                                          "status %0d, got byte %02h has %0b eom %0b ",
                                          "status %0d"},
                                         want.out_byte, want.has_byte, want.end_of_message,
                                         want.status, got.out_byte, got.has_byte,
                                         got.end_of_message, got.status));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // main sequence
    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        dir_decrypt   = 1'b0;
        key_word      = '0;
        iv_word       = '0;
        for (int k = 0; k < NB; k++) begin
            chain_bytes[k] = 8'h00;
            held_bytes[k]  = 8'h00;
        end
        reset_framing();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_encrypt_edges();
        test_live_key_write();
        test_direction_abort();
        test_spare_index();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (16) @(negedge clk);
        if (mismatches == 0 && out_beats_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/cbcx_pkg.sv
rtl/core/cbcx_chan_if.sv
rtl/core/cbcx_engine.sv
rtl/core/cbc_xor_block_cipher_pkcs7_top.sv
bench/tb.sv
